[src/trc_pkg.sv]
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants of the route cache
// Field widths, command codes and the structs passed between the cache
// modules.
// ----------------------------------------------------------------------------
package trc_pkg;

    // Fixed field widths of the stream items.
    localparam int KEY_W   = 32;
    localparam int FREQ_W  = 16;
    localparam int STAMP_W = 48;
    localparam int CMD_W   = 2;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_DATA_W   = 96;
    localparam int OUT_FIELD_W = 1 + FREQ_W + STAMP_W + 1 + KEY_W;
    localparam int OUT_DATA_W  = 104;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Decoded operation of the item that fires this cycle.
    typedef struct packed {
        logic lookup;
        logic insert;
        logic remove;
    } op_t;

    // What the slot array reports about the current key.
    typedef struct packed {
        logic               hit;
        logic               full;
        logic [FREQ_W-1:0]  freq;
        logic [STAMP_W-1:0] stamp;
        logic [KEY_W-1:0]   oldest_key;
    } slot_resp_t;

    // One result item.
    typedef struct packed {
        logic               hit;
        logic [FREQ_W-1:0]  freq;
        logic [STAMP_W-1:0] age;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } res_t;

endpackage

[src/trc_slots.sv]
// ----------------------------------------------------------------------------
// trc_slots: associative slot array
// Holds the valid bits, keys, frequencies and stamps, matches the key in all
// slots at once, and keeps an age-order matrix so the oldest entry is known
// without a search over the stamps.
// ----------------------------------------------------------------------------
module trc_slots
    import trc_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 32,
    parameter int FREQ_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  op_t                op,
    input  logic [KEY_W-1:0]   key,
    input  logic [FREQ_W-1:0]  freq,
    input  logic [STAMP_W-1:0] now,
    output slot_resp_t         resp
);

    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [KEY_BITS-1:0]  key_reg   [ENTRIES];
    logic [FREQ_BITS-1:0] freq_reg  [ENTRIES];
    logic [STAMP_W-1:0]   stamp_reg [ENTRIES];
    // older_reg[i][j] is set when slot i orders before slot j (older stamp,
    // or equal stamp and lower slot).
    logic [ENTRIES-1:0]   older_reg [ENTRIES];

    logic [KEY_BITS-1:0]  key_w;
    logic [ENTRIES-1:0]   match_raw;
    logic [ENTRIES-1:0]   match_oh;
    logic [ENTRIES-1:0]   free_raw;
    logic [ENTRIES-1:0]   free_oh;
    logic [ENTRIES-1:0]   oldest_oh;
    logic [ENTRIES-1:0]   target_oh;
    logic [ENTRIES-1:0]   now_lt;
    logic [ENTRIES-1:0]   now_eq;
    logic                 hit;
    logic                 free_any;
    logic [FREQ_BITS-1:0] rd_freq;
    logic [STAMP_W-1:0]   rd_stamp;
    logic [KEY_BITS-1:0]  rd_oldest_key;

    assign key_w = key[KEY_BITS-1:0];

    // Parallel key match and stamp compare in every slot.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_raw[i] = valid_reg[i] && (key_reg[i] == key_w);
            now_lt[i]    = now < stamp_reg[i];
            now_eq[i]    = now == stamp_reg[i];
        end
    end

    // Lowest matching and lowest free slot, as one-hot vectors.
    assign free_raw = ~valid_reg;
    assign match_oh = match_raw & (~match_raw + ENTRIES'(1));
    assign free_oh  = free_raw & (~free_raw + ENTRIES'(1));
    assign hit      = |match_raw;
    assign free_any = |free_raw;

    // The oldest valid slot orders before every other valid slot.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            oldest_oh[i] = valid_reg[i]
                && (&(older_reg[i] | free_raw | (ENTRIES'(1) << i)));
        end
    end

    // Insert target: own slot, else lowest free slot, else the oldest.
    assign target_oh = hit ? match_oh : (free_any ? free_oh : oldest_oh);

    // One-hot read of the matched and the oldest entry.
    always_comb
    begin
        rd_freq       = '0;
        rd_stamp      = '0;
        rd_oldest_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_oh[i])
            begin
                rd_freq  = rd_freq | freq_reg[i];
                rd_stamp = rd_stamp | stamp_reg[i];
            end
            if (oldest_oh[i])
            begin
                rd_oldest_key = rd_oldest_key | key_reg[i];
            end
        end
    end

    assign resp.hit        = hit;
    assign resp.full       = !free_any;
    assign resp.freq       = FREQ_W'(rd_freq);
    assign resp.stamp      = rd_stamp;
    assign resp.oldest_key = KEY_W'(rd_oldest_key);

    // Valid bits: set on insert, cleared on a remove that hits.
    always_comb
    begin
        valid_next = valid_reg;
        if (op.insert)
        begin
            valid_next = valid_reg | target_oh;
        end
        else if (op.remove)
        begin
            valid_next = valid_reg & ~match_oh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload and the order row and column of the written slot.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (op.insert && target_oh[i])
            begin
                key_reg[i]   <= key_w;
                freq_reg[i]  <= freq[FREQ_BITS-1:0];
                stamp_reg[i] <= now;
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (j != i)
                    begin
                        older_reg[i][j] <= now_lt[j] || (now_eq[j] && (i < j));
                        older_reg[j][i] <= !(now_lt[j] || (now_eq[j] && (i < j)));
                    end
                end
            end
        end
    end

endmodule

[src/trc_result.sv]
// ----------------------------------------------------------------------------
// trc_result: result formatting
// Works out the age with saturation and zeroes the fields that the command
// does not report.
// ----------------------------------------------------------------------------
module trc_result
    import trc_pkg::*;
(
    input  op_t                op,
    input  slot_resp_t         resp,
    input  logic [STAMP_W-1:0] now,
    output res_t               res
);

    logic [STAMP_W-1:0] age;
    logic               lookup_hit;
    logic               evict;

    // Age saturates at zero when time runs backwards.
    assign age = (now >= resp.stamp) ? (now - resp.stamp) : '0;

    assign lookup_hit = op.lookup && resp.hit;
    assign evict      = op.insert && !resp.hit && resp.full;

    // Only defined commands report anything.
    always_comb
    begin
        res.hit         = resp.hit && (op.lookup || op.insert || op.remove);
        res.freq        = lookup_hit ? resp.freq : '0;
        res.age         = lookup_hit ? age : '0;
        res.evicted     = evict;
        res.evicted_key = evict ? resp.oldest_key : '0;
    end

endmodule

[src/timestamped_route_cache_unit.sv]
// ----------------------------------------------------------------------------
// timestamped_route_cache_unit: fully associative route cache
// From input accept to result valid an item passes through two registers:
// the input register and the result register.
// Throughput is one item per cycle unless the result side stalls; slot state
// is updated in the same cycle that an item moves into the result register.
// Reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module timestamped_route_cache_unit
    import trc_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 32,
    parameter int FREQ_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key [31:0], freq_in [47:32], now_us [95:48]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command [1:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit [0], freq_out [16:1], age_us [64:17], evicted [65],
    // evicted_key [97:66], zero padding [103:98]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Stored key and frequency widths, limited by the field widths.
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int FW = (FREQ_BITS < FREQ_W) ? FREQ_BITS : FREQ_W;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [STAMP_W-1:0] now_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               res_reg;
    res_t               res_next;
    logic               advance;
    logic               in_fire;
    op_t                op;
    slot_resp_t         resp;

    // The held item moves on when the result register is free or drains.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Command decode, qualified by the move into the result register.
    assign op.lookup = advance && (cmd_reg == CMD_LOOKUP);
    assign op.insert = advance && (cmd_reg == CMD_INSERT);
    assign op.remove = advance && (cmd_reg == CMD_REMOVE);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input item register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= s_axis_tuser;
            key_reg  <= s_axis_tdata[31:0];
            freq_reg <= s_axis_tdata[47:32];
            now_reg  <= s_axis_tdata[95:48];
        end
    end

    trc_slots #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KW),
        .FREQ_BITS (FW)
    ) u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .key   (key_reg),
        .freq  (freq_reg),
        .now   (now_reg),
        .resp  (resp)
    );

    trc_result u_result (
        .op   (op),
        .resp (resp),
        .now  (now_reg),
        .res  (res_next)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_reg.evicted_key, res_reg.evicted,
                            res_reg.age, res_reg.freq, res_reg.hit};

endmodule

[src/trc_checker.sv]
// ----------------------------------------------------------------------------
// trc_checker: port-level checks of the route cache
// Watches the stream ports of the top level and checks result consistency
// and output timing.
// ----------------------------------------------------------------------------
module trc_checker
    import trc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An eviction only happens on an insert that missed.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[65] |-> !m_axis_tdata[0])
        else $error("eviction reported together with a hit");

    // A miss carries no frequency and no age.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0]
        |-> (m_axis_tdata[16:1] == '0) && (m_axis_tdata[64:17] == '0))
        else $error("miss with nonzero frequency or age");

    // The evicted key is zero unless an entry was evicted.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[65] |-> m_axis_tdata[97:66] == '0)
        else $error("evicted key without eviction");

    // A result appears on an idle output only for an item taken at the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input item");

endmodule

bind timestamped_route_cache_unit trc_checker u_trc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/tb_timestamped_route_cache_unit.sv]
// ----------------------------------------------------------------------------
// tb_timestamped_route_cache_unit: self-checking bench for the route cache
// Drives lookup, insert and remove items into the stream input and checks
// every result item against a typed-in expectation or a behavioral cache
// kept in the bench. A directed table covers the field extremes, time going
// backwards, reinsert of a present key and an eviction tie. Random traffic
// with a small key pool then runs under several idle and stall patterns,
// including one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_timestamped_route_cache_unit
    import trc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CACHE_SLOTS = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASES = 4;
    localparam int KEY_POOL = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // One request item, with an optional typed-in expectation.
    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [FREQ_W-1:0]  freq;
        logic [STAMP_W-1:0] now;
        bit                 typed;
        res_t               want;
    } route_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Behavioral copy of the cache contents.
    logic               cache_valid [CACHE_SLOTS];
    logic [KEY_W-1:0]   cache_key   [CACHE_SLOTS];
    logic [FREQ_W-1:0]  cache_freq  [CACHE_SLOTS];
    logic [STAMP_W-1:0] cache_stamp [CACHE_SLOTS];

    res_t               pending_results [$];
    route_req_t         directed_rows [$];
    logic [KEY_W-1:0]   key_pool [KEY_POOL];
    logic [STAMP_W-1:0] clock_us;
    int                 errors = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    bit                 rx_hold = 1'b0;
    bit                 pressure_go = 1'b0;

    timestamped_route_cache_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side ready, with random stalls and the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver stall while the sender keeps offering items, so the
    // cache output fills and input ready drops.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Applies one item to the cache copy and works out its result item.
    task automatic cache_access(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                input logic [FREQ_W-1:0] freq,
                                input logic [STAMP_W-1:0] now, output res_t res);
        int match;
        int free_idx;
        int oldest;
        int target;
        match = -1;
        free_idx = -1;
        oldest = -1;
        res = '0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (cache_valid[i])
            begin
                if (match < 0 && cache_key[i] == key)
                    match = i;
                if (oldest < 0 || cache_stamp[i] < cache_stamp[oldest])
                    oldest = i;
            end
            else if (free_idx < 0)
            begin
                free_idx = i;
            end
        end
        case (cmd)
            CMD_LOOKUP:
            begin
                if (match >= 0)
                begin
                    res.hit = 1'b1;
                    res.freq = cache_freq[match];
                    // Age saturates at zero when time runs backwards.
                    res.age = (now >= cache_stamp[match]) ? now - cache_stamp[match] : '0;
                end
            end
            CMD_INSERT:
            begin
                if (match >= 0)
                begin
                    res.hit = 1'b1;
                    target = match;
                end
                else if (free_idx >= 0)
                begin
                    target = free_idx;
                end
                else
                begin
                    target = oldest;
                    res.evicted = 1'b1;
                    res.evicted_key = cache_key[oldest];
                end
                cache_valid[target] = 1'b1;
                cache_key[target] = key;
                cache_freq[target] = freq;
                cache_stamp[target] = now;
            end
            CMD_REMOVE:
            begin
                if (match >= 0)
                begin
                    res.hit = 1'b1;
                    cache_valid[match] = 1'b0;
                end
            end
            default:
            begin
                // The unused command code leaves the cache alone.
            end
        endcase
    endtask

    // Offers one item, waits for the handshake and records its expectation.
    task automatic offer_item(input route_req_t req);
        res_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {req.now, req.freq, req.key};
        s_axis_tuser <= req.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        cache_access(req.cmd, req.key, req.freq, req.now, predicted);
        if (req.typed)
            pending_results.push_back(req.want);
        else
            pending_results.push_back(predicted);
    endtask

    // Appends one row to the directed table.
    function automatic void add_row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                    logic [FREQ_W-1:0] freq, logic [STAMP_W-1:0] now,
                                    bit typed, res_t want);
        route_req_t row;
        row.cmd = cmd;
        row.key = key;
        row.freq = freq;
        row.now = now;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // Random item: keys mostly from a small pool so hits and evictions are
    // frequent, time mostly moving forward with repeated stamps.
    function automatic route_req_t random_req();
        route_req_t req;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            req.cmd = CMD_LOOKUP;
        else if (pick < 78)
            req.cmd = CMD_INSERT;
        else if (pick < 97)
            req.cmd = CMD_REMOVE;
        else
            req.cmd = CMD_UNUSED;
        if ($urandom_range(9) == 0)
            req.key = $urandom();
        else
            req.key = key_pool[$urandom_range(KEY_POOL - 1)];
        req.freq = 16'($urandom());
        pick = $urandom_range(99);
        if (pick < 2)
        begin
            // Jump to a random time, exercising the upper time bits.
            clock_us = {16'($urandom()), 32'($urandom())};
            req.now = clock_us;
        end
        else if (pick < 5)
        begin
            // Stale time stamp at or below the current clock.
            req.now = clock_us - STAMP_W'($urandom_range(500));
        end
        else
        begin
            if ($urandom_range(3) != 0)
                clock_us = clock_us + STAMP_W'($urandom_range(300));
            req.now = clock_us;
        end
        req.typed = 1'b0;
        req.want = '0;
        return req;
    endfunction

    // Compares one result field and counts a mismatch.
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Result monitor: each accepted item is checked against the oldest
    // expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item 0x%0h arrived with nothing expected", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", 64'(want.hit), 64'(m_axis_tdata[0]));
                check_field("freq_out", 64'(want.freq), 64'(m_axis_tdata[16:1]));
                check_field("age_us", 64'(want.age), 64'(m_axis_tdata[64:17]));
                check_field("evicted", 64'(want.evicted), 64'(m_axis_tdata[65]));
                check_field("evicted_key", 64'(want.evicted_key), 64'(m_axis_tdata[97:66]));
                check_field("padding", 64'd0, 64'(m_axis_tdata[OUT_DATA_W-1:OUT_FIELD_W]));
            end
        end
    end

    // Main sequence.
    initial
    begin
        int idle_pct [PHASES];
        int stall_pct [PHASES];
        res_t want;

        idle_pct = '{0, 78, 0, 8};
        stall_pct = '{0, 0, 78, 8};
        for (int i = 0; i < CACHE_SLOTS; i++)
            cache_valid[i] = 1'b0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom();
        clock_us = 48'd1000;

        // Directed table.
        add_row(CMD_LOOKUP, 32'h0, 16'h0, 48'h0, 1'b1, '0);
        add_row(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0, 48'h0, 1'b1, '0);
        add_row(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, STAMP_MAX, 1'b1, '0);
        add_row(CMD_INSERT, 32'h0, 16'hFFFF, 48'h0, 1'b1, '0);
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 16'h0, STAMP_MAX, 1'b1, '0);
        want = '0;
        want.hit = 1'b1;
        want.freq = 16'hFFFF;
        want.age = STAMP_MAX;
        add_row(CMD_LOOKUP, 32'h0, 16'h0, STAMP_MAX, 1'b1, want);
        // Time going backwards gives an age of zero.
        want = '0;
        want.hit = 1'b1;
        add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0, 48'h0, 1'b1, want);
        // Reinsert of a present key refreshes its slot without eviction.
        add_row(CMD_INSERT, 32'h0, 16'h1234, 48'd5, 1'b1, want);
        add_row(CMD_REMOVE, 32'h0, 16'h0, 48'd5, 1'b1, want);
        // Fill every free slot with the same stamp, then force an eviction;
        // the tie goes to the lowest slot.
        for (int i = 0; i < CACHE_SLOTS - 1; i++)
            add_row(CMD_INSERT, 32'h5A5A_0000 + i, 16'(i), 48'd7, 1'b0, '0);
        want = '0;
        want.evicted = 1'b1;
        want.evicted_key = 32'h5A5A_0000;
        add_row(CMD_INSERT, 32'h0000_BEEF, 16'h00AA, 48'd7, 1'b1, want);

        // Reset.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i]);

        // Random traffic under each idle pattern; the first one also carries
        // the long receiver stall.
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            if (p == 0)
                pressure_go = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                offer_item(random_req());
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give a stray result time to show up.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
src/trc_pkg.sv
src/trc_slots.sv
src/trc_result.sv
src/timestamped_route_cache_unit.sv
src/trc_checker.sv
test/tb_timestamped_route_cache_unit.sv
